// File: design/sdce_pkg.sv
// ----------------------------------------------------------------------------
// sdce_pkg: shared types, constants and arithmetic helpers
// Item structs, frame type and the three-to-one mixing function.
// ----------------------------------------------------------------------------
package sdce_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int CARRY_W    = 14;
   localparam int DELAY_W    = 10;
   localparam int ECHO_DEPTH = 512;
   localparam int ECHO_AW    = $clog2(ECHO_DEPTH);
   localparam int CMP_W      = (ECHO_AW + 1 > DELAY_W) ? ECHO_AW + 1 : DELAY_W;
   localparam int MIX_W      = SAMPLE_W + 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type first_left;
      sample_type first_right;
      sample_type second_left;
      sample_type second_right;
   } req_type;

   typedef struct packed {
      sample_type out_left;
      sample_type out_right;
   } rsp_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

   typedef struct packed {
      logic rd_en;   // fetch delayed frame for the item being accepted
      logic wr_en;   // write back the item leaving the echo stage
   } echo_ctrl_type;

   // floor((3*own + other) / 4); result always fits a sample
   function automatic sample_type mix31(input sample_type own, input sample_type other);
      logic signed [MIX_W-1:0] sum;
      sum = (MIX_W'(own) <<< 1) + MIX_W'(own) + MIX_W'(other);
      return sum[MIX_W-1:2];
   endfunction

endpackage

// File: design/sdce_mix.sv
// ----------------------------------------------------------------------------
// sdce_mix: 2:1 decimation and crossfeed
// Holds the quarter-sample carry per channel; combinational crossfeed output.
// ----------------------------------------------------------------------------
module sdce_mix (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  sdce_pkg::req_type req,
   output sdce_pkg::frame_type xfeed
);
   import sdce_pkg::*;

   logic signed [CARRY_W-1:0] carry_left_ff, carry_right_ff;
   logic signed [CARRY_W-1:0] carry_left_in, carry_right_in;
   sample_type                dec_left, dec_right;

   // carry + first/2 + second/4, floor shifts
   function automatic sample_type decim(input logic signed [CARRY_W-1:0] carry,
                                        input sample_type first,
                                        input logic signed [CARRY_W-1:0] quarter);
      logic signed [MIX_W-1:0] sum;
      sum = MIX_W'(carry) + MIX_W'($signed(first[SAMPLE_W-1:1])) + MIX_W'(quarter);
      return sum[SAMPLE_W-1:0];
   endfunction

   always_comb begin
      carry_left_in  = req.second_left[SAMPLE_W-1:2];
      carry_right_in = req.second_right[SAMPLE_W-1:2];
      dec_left       = decim(carry_left_ff, req.first_left, carry_left_in);
      dec_right      = decim(carry_right_ff, req.first_right, carry_right_in);
      xfeed.left     = mix31(dec_left, dec_right);
      xfeed.right    = mix31(dec_right, dec_left);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_left_ff  <= '0;
         carry_right_ff <= '0;
      end else if (accept) begin
         carry_left_ff  <= carry_left_in;
         carry_right_ff <= carry_right_in;
      end
   end

endmodule

// File: design/sdce_echo.sv
// ----------------------------------------------------------------------------
// sdce_echo: cross delay ring with feedback
// Frame memory, ring position, post-reset clearing sweep and echo mix.
// ----------------------------------------------------------------------------
module sdce_echo (
   input  logic                           clock,
   input  logic                           reset,
   input  sdce_pkg::echo_ctrl_type        ctrl,
   input  logic [sdce_pkg::DELAY_W-1:0]   delay_frames,
   input  sdce_pkg::frame_type            xfeed,
   output sdce_pkg::frame_type            echo_out,
   output logic                           echo_on,
   output logic                           busy
);
   import sdce_pkg::*;

   logic [2*SAMPLE_W-1:0] mem [ECHO_DEPTH];
   logic [2*SAMPLE_W-1:0] rdata_ff;
   logic [ECHO_AW-1:0]    wr_addr_ff;
   logic [ECHO_AW-1:0]    pos_ff, pos_in;
   logic [ECHO_AW-1:0]    clr_idx_ff;
   logic                  busy_ff;
   logic [CMP_W-1:0]      len, pos_inc;
   sample_type            dly_left, dly_right;

   always_comb begin
      len = (CMP_W'(delay_frames) > CMP_W'(ECHO_DEPTH)) ? CMP_W'(ECHO_DEPTH)
                                                       : CMP_W'(delay_frames);
      echo_on = (len >= CMP_W'(2));
      pos_inc = CMP_W'(pos_ff) + CMP_W'(1);
      pos_in  = (pos_inc >= len) ? '0 : pos_inc[ECHO_AW-1:0];
      // low half left, high half right
      dly_left       = rdata_ff[SAMPLE_W-1:0];
      dly_right      = rdata_ff[2*SAMPLE_W-1:SAMPLE_W];
      echo_out.left  = mix31(xfeed.left, dly_right);
      echo_out.right = mix31(xfeed.right, dly_left);
      busy           = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (ctrl.wr_en) begin
         mem[wr_addr_ff] <= {echo_out.right, echo_out.left};
      end
      if (ctrl.rd_en) begin
         rdata_ff   <= mem[pos_ff];
         wr_addr_ff <= pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         clr_idx_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         if (busy_ff) begin
            clr_idx_ff <= clr_idx_ff + ECHO_AW'(1);
            if (clr_idx_ff == ECHO_AW'(ECHO_DEPTH - 1)) begin
               busy_ff <= 1'b0;
            end
         end
         if (ctrl.rd_en) begin
            pos_ff <= pos_in;
         end
      end
   end

endmodule

// File: design/stereo_decimate_crossfeed_echo.sv
// ----------------------------------------------------------------------------
// stereo_decimate_crossfeed_echo: 2:1 stereo decimator, crossfeed, cross delay
// Two oversampled stereo frames in, one processed frame out per item.
// ----------------------------------------------------------------------------
// Path: echo stage register, then result register; rsp_stall can hold either.
// Throughput: one item per cycle while req_stall is low; the echo memory has one
//   read and one write port; fetched at acceptance, written back one stage on.
// Reset: carries, ring position and delay length clear at once; the echo
//   memory is then zeroed by a sweep over its 512 entries; req_stall stays high.
// csr writes are taken at any time (csr_ready is tied high).
module stereo_decimate_crossfeed_echo (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sdce_pkg::req_type             req_payload,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sdce_pkg::rsp_type             rsp_payload,
   // delay length register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sdce_pkg::DELAY_W-1:0]  csr_data
);
   import sdce_pkg::*;

   logic [DELAY_W-1:0] delay_frames_ff;

   // echo stage: crossfed frame waiting for its delayed frame
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_echo_ff;
   frame_type          s1_frame_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;

   logic               accept, advance, out_free;
   logic               echo_on, busy;
   frame_type          xfeed, echo_out;
   echo_ctrl_type      echo_ctrl;

   // result register can load when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = busy || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // delayed frame is fetched as the item enters; stored back as it leaves
   assign echo_ctrl.rd_en = accept && echo_on;
   assign echo_ctrl.wr_en = advance && s1_echo_ff;

   sdce_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .xfeed  (xfeed)
   );

   sdce_echo u_echo (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (echo_ctrl),
      .delay_frames (delay_frames_ff),
      .xfeed        (s1_frame_ff),
      .echo_out     (echo_out),
      .echo_on      (echo_on),
      .busy         (busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_frames_ff <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            delay_frames_ff <= csr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_frame_ff <= xfeed;
         s1_echo_ff  <= echo_on;
      end
      if (advance) begin
         if (s1_echo_ff) begin
            rsp_ff.out_left  <= echo_out.left;
            rsp_ff.out_right <= echo_out.right;
         end else begin
            // echo bypassed: crossfeed result goes straight out
            rsp_ff.out_left  <= s1_frame_ff.left;
            rsp_ff.out_right <= s1_frame_ff.right;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
